// ===== rtl/cwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and wiring tables of the cable wiremap checker
// no dependencies; used by cwm_step and cable_wiremap_checker

package cwm_pkg;

    // geometry
    localparam int WIRES   = 8;
    localparam int PINS    = 8;
    localparam int WIRE_W  = $clog2(WIRES);
    localparam int PIN_W   = $clog2(PINS);
    localparam int MATCH_W = $clog2(WIRES + 1);
    localparam int NIB_W   = 4;
    localparam int SRC_W   = NIB_W * PINS;

    // field widths
    localparam int MODE_W  = 3;
    localparam int MAP_W   = 24;
    localparam int TALLY_W = 10;
    localparam int DRIVE_W = 8;
    localparam int RECV_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // wiring mode codes
    localparam logic [MODE_W-1:0] MODE_STRAIGHT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CROSS    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FULL     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CUSTOM   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEBUG    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 2'd2;

    // reset values
    localparam logic [MAP_W-1:0]   CUSTOM_RESET = 24'hFAC688;
    localparam logic [TALLY_W-1:0] ROUNDS_RESET = 10'd5;
    localparam logic [TALLY_W-1:0] TALLY_MAX    = 10'd1023;

    // debug nibble marks
    localparam logic [NIB_W-1:0] MARK_NONE    = 4'd0;
    localparam logic [NIB_W-1:0] MARK_SEVERAL = 4'd9;

    // near wire expected on each far pin
    typedef logic [2:0] t_pin_wire;
    localparam t_pin_wire CROSS_MAP [PINS] = '{3'd2, 3'd5, 3'd0, 3'd3, 3'd4, 3'd1, 3'd6, 3'd7};
    localparam t_pin_wire FULL_MAP  [PINS] = '{3'd2, 3'd5, 3'd0, 3'd6, 3'd7, 3'd1, 3'd3, 3'd4};

    typedef struct packed {
        logic [MODE_W-1:0]  wiring_mode;
        logic [MAP_W-1:0]   custom_map;
        logic [TALLY_W-1:0] round_count;
    } t_cfg;

    typedef struct packed {
        logic                running;
        logic                finished;
        logic [WIRE_W-1:0]   wire_index;
        logic [MATCH_W-1:0]  lines_matched;
        logic [TALLY_W-1:0]  rounds_finished;
        logic [TALLY_W-1:0]  ok_rounds;
        logic [TALLY_W-1:0]  ng_rounds;
        logic [SRC_W-1:0]    source_map;
    } t_state;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_next;
        logic               line_ok;
        logic               round_done;
        logic               round_ok;
        logic [TALLY_W-1:0] ok_tally;
        logic [TALLY_W-1:0] ng_tally;
        logic               run_done;
        logic [SRC_W-1:0]   pin_sources;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/cwm_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one step of the wiremap checker: next state and result for one sample
// depends on cwm_pkg

module cwm_step import cwm_pkg::*; (
    input  wire logic              i_begin_req,
    input  wire logic [RECV_W-1:0] i_received,
    input  wire t_cfg              i_cfg,
    input  wire t_state            i_state,
    output t_state                 o_state_next,
    output t_result                o_result
);

    localparam int CMP_W = (WIRE_W > 3) ? WIRE_W : 3;

    // near wire expected on a far pin under the current mode
    function automatic t_pin_wire wire_for_pin(input logic [PIN_W-1:0] pin);
        t_pin_wire w;
        case (i_cfg.wiring_mode)
            MODE_CROSS:  w = CROSS_MAP[pin];
            MODE_FULL:   w = FULL_MAP[pin];
            MODE_CUSTOM: w = i_cfg.custom_map[3*pin +: 3];
            default:     w = t_pin_wire'(pin);
        endcase
        return w;
    endfunction

    // one-hot drive pattern, wires past the port width dropped
    function automatic logic [DRIVE_W-1:0] one_hot(input logic [WIRE_W-1:0] w);
        logic [DRIVE_W-1:0] oh;
        for (int b = 0; b < DRIVE_W; b++) begin
            oh[b] = (CMP_W'(w) == CMP_W'(b));
        end
        return oh;
    endfunction

    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
        return (v < TALLY_MAX) ? v + 1'b1 : v;
    endfunction

    logic               debug;
    logic               last_wire;
    logic [RECV_W-1:0]  expected;
    logic [NIB_W-1:0]   wire_num;
    logic [SRC_W-1:0]   src_upd;
    logic [MATCH_W-1:0] matched_new;

    assign debug     = (i_cfg.wiring_mode == MODE_DEBUG);
    assign last_wire = (i_state.wire_index == WIRE_W'(WIRES - 1));
    assign wire_num  = NIB_W'(i_state.wire_index) + 1'b1;

    // expected far-end pattern for the wire being driven
    always_comb begin
        expected = '0;
        for (int k = 0; k < PINS; k++) begin
            expected[k] = (CMP_W'(wire_for_pin(PIN_W'(k))) == CMP_W'(i_state.wire_index));
        end
    end

    // debug source map with this sample folded in, one nibble per pin
    always_comb begin
        src_upd = i_state.source_map;
        for (int k = 0; k < PINS; k++) begin
            if (i_received[k]) begin
                src_upd[NIB_W*k +: NIB_W] =
                    (i_state.source_map[NIB_W*k +: NIB_W] == MARK_NONE) ? wire_num
                                                                       : MARK_SEVERAL;
            end
        end
    end

    // state update and result
    always_comb begin
        o_state_next = i_state;
        o_result     = '0;
        matched_new  = i_state.lines_matched;

        if (i_begin_req) begin
            o_state_next         = '0;
            o_state_next.running = 1'b1;
            if (!debug && (i_cfg.round_count == '0)) begin
                o_state_next.running  = 1'b0;
                o_state_next.finished = 1'b1;
            end else begin
                o_result.drive_next = one_hot('0);
            end
        end else if (i_state.running) begin
            if (debug) begin
                o_result.pin_sources    = src_upd;
                o_state_next.source_map = src_upd;
            end else if (i_received == expected) begin
                o_result.line_ok = 1'b1;
                matched_new      = i_state.lines_matched + 1'b1;
            end
            o_state_next.lines_matched = matched_new;

            // end of round
            if (last_wire) begin
                o_result.round_done = 1'b1;
                if (!debug) begin
                    o_result.round_ok = (matched_new >= MATCH_W'(WIRES));
                    if (o_result.round_ok) begin
                        o_state_next.ok_rounds = sat_inc(i_state.ok_rounds);
                    end else begin
                        o_state_next.ng_rounds = sat_inc(i_state.ng_rounds);
                    end
                    o_state_next.rounds_finished = sat_inc(i_state.rounds_finished);
                end
                o_state_next.wire_index    = '0;
                o_state_next.lines_matched = '0;
                o_state_next.source_map    = '0;
            end else begin
                o_state_next.wire_index = i_state.wire_index + 1'b1;
            end

            // end of run, checked every step
            if (!debug && (o_state_next.rounds_finished >= i_cfg.round_count)) begin
                o_state_next.running  = 1'b0;
                o_state_next.finished = 1'b1;
            end else begin
                o_result.drive_next = one_hot(o_state_next.wire_index);
            end
        end else begin
            o_result.pin_sources = i_state.source_map;
        end

        o_result.ok_tally = o_state_next.ok_rounds;
        o_result.ng_tally = o_state_next.ng_rounds;
        o_result.run_done = o_state_next.finished;
    end

endmodule

`default_nettype wire

// ===== rtl/cable_wiremap_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// top level of the eight-wire cable wiremap checker
// depends on cwm_pkg and cwm_step
//
// Each transaction on the input channel is one step of the tester: either a
// begin request or the far-end sample taken while the last drive_next pattern
// was applied. Every input transaction yields exactly one result transaction.
// The block takes one transaction per cycle while the result is not stalled;
// an accepted input goes through the input register, then the combinational
// step logic into the result register. The run state lives in registers
// updated by that one step, so throughput is set by that single stage. A
// stalled result holds the step stage, and the input register then absorbs
// at most one more transaction before o_in_stall rises. Configuration writes
// are always ready and should be issued only while no transaction is in flight.

module cable_wiremap_checker import cwm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_begin_req,
    input  wire logic [RECV_W-1:0]     i_received,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [DRIVE_W-1:0]         o_drive_next,
    output logic                       o_line_ok,
    output logic                       o_round_done,
    output logic                       o_round_ok,
    output logic [TALLY_W-1:0]         o_ok_tally,
    output logic [TALLY_W-1:0]         o_ng_tally,
    output logic                       o_run_done,
    output logic [SRC_W-1:0]           o_pin_sources
);

    t_cfg              r_cfg;
    t_state            r_state;
    t_state            n_state;
    t_result           r_res;
    t_result           n_res;
    logic              r_in_valid;
    logic              r_begin;
    logic [RECV_W-1:0] r_recv;
    logic              r_out_valid;
    logic              fire;
    logic              in_take;

    // handshake
    assign fire        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !fire;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // step logic
    cwm_step u_step (
        .i_begin_req  (r_begin),
        .i_received   (r_recv),
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .o_state_next (n_state),
        .o_result     (n_res)
    );

    // control state, configuration and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_state            <= '0;
            r_cfg.wiring_mode  <= MODE_STRAIGHT;
            r_cfg.custom_map   <= CUSTOM_RESET;
            r_cfg.round_count  <= ROUNDS_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end

            if (fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE:   r_cfg.wiring_mode <= i_cfg_data[MODE_W-1:0];
                    REG_MAP:    r_cfg.custom_map  <= i_cfg_data[MAP_W-1:0];
                    REG_ROUNDS: r_cfg.round_count <= i_cfg_data[TALLY_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_begin <= i_begin_req;
            r_recv  <= i_received;
        end
        if (fire) begin
            r_res <= n_res;
        end
    end

    // result ports
    assign o_out_valid   = r_out_valid;
    assign o_drive_next  = r_res.drive_next;
    assign o_line_ok     = r_res.line_ok;
    assign o_round_done  = r_res.round_done;
    assign o_round_ok    = r_res.round_ok;
    assign o_ok_tally    = r_res.ok_tally;
    assign o_ng_tally    = r_res.ng_tally;
    assign o_run_done    = r_res.run_done;
    assign o_pin_sources = r_res.pin_sources;

    // checks
    a_drive_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(o_drive_next))
        else $error("drive pattern not one-hot");

    a_round_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_round_ok) |-> o_round_done)
        else $error("round pass without round end");

    a_run_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.running |-> !r_state.finished)
        else $error("run both active and finished");

    a_debug_no_judge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (o_pin_sources != '0)) |-> (!o_line_ok && !o_round_ok))
        else $error("debug map reported alongside a check verdict");

    a_done_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_run_done) |-> (o_drive_next == '0))
        else $error("drive active after run end");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the cable wiremap checker: directed table, then random runs
// depends on cwm_pkg and cable_wiremap_checker; carries its own model of the tester

module tb_top;
    import cwm_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int QUIET_LIMIT  = 2000;
    localparam int GAP_HEAVY    = 53;
    localparam int GAP_LIGHT    = 12;
    localparam int SHOWN_FAULTS = 10;

    // wiring mode with no meaning of its own, checks like straight
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    typedef enum logic [1:0] {ROW_CFG, ROW_STEP, ROW_FIXED} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  begin_req;
        logic [RECV_W-1:0]     recv;
        t_result               want;
    } t_row;

    // results that can be read straight off the behaviour
    localparam t_result RES_QUIET     = '0;
    localparam t_result RES_BEGIN     = '{drive_next: 8'h01, default: '0};
    localparam t_result RES_EMPTY_RUN = '{run_done: 1'b1, default: '0};

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic                  i_begin_req = 1'b0;
    logic [RECV_W-1:0]     i_received  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [DRIVE_W-1:0]    o_drive_next;
    logic                  o_line_ok;
    logic                  o_round_done;
    logic                  o_round_ok;
    logic [TALLY_W-1:0]    o_ok_tally;
    logic [TALLY_W-1:0]    o_ng_tally;
    logic                  o_run_done;
    logic [SRC_W-1:0]      o_pin_sources;

    // mirrored registers
    logic [MODE_W-1:0]  cfg_mode   = MODE_STRAIGHT;
    logic [MAP_W-1:0]   cfg_map    = CUSTOM_RESET;
    logic [TALLY_W-1:0] cfg_rounds = ROUNDS_RESET;

    // mirrored tester state
    int unsigned        m_wire     = 0;
    int unsigned        m_matched  = 0;
    logic [TALLY_W-1:0] m_rounds   = '0;
    logic [TALLY_W-1:0] m_ok       = '0;
    logic [TALLY_W-1:0] m_ng       = '0;
    logic [SRC_W-1:0]   m_srcmap   = '0;
    logic               m_running  = 1'b0;
    logic               m_finished = 1'b0;

    t_result verdict_q [$];
    int      fault_count  = 0;
    int      quiet_cycles = 0;
    int      in_gap_pct   = 0;
    int      out_stall_pct = 0;

    // directed stimulus, run from reset in this order
    t_row directed_rows [35] = '{
        '{ROW_FIXED, REG_MODE,   '0,                         1'b0, 8'hFF, RES_QUIET},
        '{ROW_FIXED, REG_MODE,   '0,                         1'b1, 8'hFF, RES_BEGIN},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h01, RES_QUIET},
        '{ROW_FIXED, REG_MODE,   '0,                         1'b1, 8'h00, RES_BEGIN},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h01, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'hFF, RES_QUIET},
        '{ROW_CFG,   REG_MODE,   CFG_DATA_W'(MODE_UNUSED),   1'b0, 8'h00, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h04, RES_QUIET},
        '{ROW_CFG,   REG_MODE,   CFG_DATA_W'(MODE_CROSS),    1'b0, 8'h00, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h08, RES_QUIET},
        '{ROW_CFG,   REG_MODE,   CFG_DATA_W'(MODE_FULL),     1'b0, 8'h00, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h80, RES_QUIET},
        '{ROW_CFG,   REG_MODE,   CFG_DATA_W'(MODE_CUSTOM),   1'b0, 8'h00, RES_QUIET},
        '{ROW_CFG,   REG_MAP,    '0,                         1'b0, 8'h00, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h00, RES_QUIET},
        '{ROW_CFG,   REG_MAP,    24'hFFFFFF,                 1'b0, 8'h00, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h00, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'hFF, RES_QUIET},
        '{ROW_CFG,   REG_MODE,   CFG_DATA_W'(MODE_DEBUG),    1'b0, 8'h00, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'hFF, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h03, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h00, RES_QUIET},
        '{ROW_CFG,   REG_ROUNDS, '0,                         1'b0, 8'h00, RES_QUIET},
        '{ROW_CFG,   REG_MODE,   CFG_DATA_W'(MODE_STRAIGHT), 1'b0, 8'h00, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h10, RES_QUIET},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h00, RES_QUIET},
        '{ROW_FIXED, REG_MODE,   '0,                         1'b1, 8'hAA, RES_EMPTY_RUN},
        '{ROW_FIXED, REG_MODE,   '0,                         1'b0, 8'h55, RES_EMPTY_RUN},
        '{ROW_CFG,   REG_MODE,   CFG_DATA_W'(MODE_DEBUG),    1'b0, 8'h00, RES_QUIET},
        '{ROW_FIXED, REG_MODE,   '0,                         1'b1, 8'h00, RES_BEGIN},
        '{ROW_STEP,  REG_MODE,   '0,                         1'b0, 8'h80, RES_QUIET},
        '{ROW_CFG,   REG_ROUNDS, 24'd999,                    1'b0, 8'h00, RES_QUIET},
        '{ROW_CFG,   REG_MAP,    CFG_DATA_W'(CUSTOM_RESET),  1'b0, 8'h00, RES_QUIET},
        '{ROW_CFG,   REG_MODE,   CFG_DATA_W'(MODE_STRAIGHT), 1'b0, 8'h00, RES_QUIET},
        '{ROW_FIXED, REG_MODE,   '0,                         1'b1, 8'h00, RES_BEGIN}
    };

    cable_wiremap_checker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_begin_req   (i_begin_req),
        .i_received    (i_received),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_drive_next  (o_drive_next),
        .o_line_ok     (o_line_ok),
        .o_round_done  (o_round_done),
        .o_round_ok    (o_round_ok),
        .o_ok_tally    (o_ok_tally),
        .o_ng_tally    (o_ng_tally),
        .o_run_done    (o_run_done),
        .o_pin_sources (o_pin_sources)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // far-end pins that should see the given near wire under the current map
    function automatic logic [RECV_W-1:0] pattern_for_wire(int unsigned w);
        logic [RECV_W-1:0] pat;
        logic [2:0]        src;
        pat = '0;
        for (int k = 0; k < PINS; k++) begin
            case (cfg_mode)
                MODE_CROSS:  src = CROSS_MAP[k];
                MODE_FULL:   src = FULL_MAP[k];
                MODE_CUSTOM: src = cfg_map[3*k +: 3];
                default:     src = 3'(k);
            endcase
            if (int'(src) == w) pat[k] = 1'b1;
        end
        return pat;
    endfunction

    // one tester step: judges a sample or starts a run, returns the result transaction
    function automatic t_result judge_sample(logic b, logic [RECV_W-1:0] r);
        t_result    res;
        logic       dbg;
        logic [3:0] cur;
        res = '0;
        dbg = (cfg_mode == MODE_DEBUG);
        if (b) begin
            m_wire     = 0;
            m_matched  = 0;
            m_rounds   = '0;
            m_ok       = '0;
            m_ng       = '0;
            m_srcmap   = '0;
            m_finished = 1'b0;
            m_running  = 1'b1;
            if (!dbg && cfg_rounds == '0) begin
                m_running  = 1'b0;
                m_finished = 1'b1;
            end else begin
                res.drive_next = 8'h01;
            end
        end else if (m_running) begin
            if (dbg) begin
                // note which wire reached each pin, marking pins reached twice
                for (int k = 0; k < PINS; k++) begin
                    if (r[k]) begin
                        cur = m_srcmap[4*k +: 4];
                        m_srcmap[4*k +: 4] = (cur == MARK_NONE) ? 4'(m_wire + 1) : MARK_SEVERAL;
                    end
                end
                res.pin_sources = m_srcmap;
            end else if (r == pattern_for_wire(m_wire)) begin
                res.line_ok = 1'b1;
                m_matched++;
            end
            m_wire++;
            // end of round: tally in check modes, tallies saturate
            if (m_wire >= WIRES) begin
                res.round_done = 1'b1;
                if (!dbg) begin
                    res.round_ok = (m_matched >= WIRES);
                    if (res.round_ok) begin
                        if (m_ok != TALLY_MAX) m_ok++;
                    end else if (m_ng != TALLY_MAX) begin
                        m_ng++;
                    end
                    if (m_rounds != TALLY_MAX) m_rounds++;
                end
                m_wire    = 0;
                m_matched = 0;
                m_srcmap  = '0;
            end
            if (!dbg && m_rounds >= cfg_rounds) begin
                m_running  = 1'b0;
                m_finished = 1'b1;
            end else begin
                res.drive_next = 8'(1 << m_wire);
            end
        end else begin
            res.pin_sources = m_srcmap;
        end
        res.ok_tally = m_ok;
        res.ng_tally = m_ng;
        res.run_done = m_finished;
        return res;
    endfunction

    task automatic report_fault(string what);
        if (fault_count < SHOWN_FAULTS) $display("%0t: %s", $time, what);
        fault_count++;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) report_fault($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    // one input transaction, called and returning at a falling edge
    task automatic send_step(input logic b, input logic [RECV_W-1:0] r,
                             input bit fixed, input t_result want);
        t_result res;
        while ($urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_begin_req <= b;
        i_received  <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = judge_sample(b, r);
        verdict_q.push_back(fixed ? want : res);
        @(negedge i_clk);
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_MODE:   cfg_mode   = data[MODE_W-1:0];
            REG_MAP:    cfg_map    = data[MAP_W-1:0];
            REG_ROUNDS: cfg_rounds = data[TALLY_W-1:0];
            default:    ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // result checking against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                report_fault("result transaction with nothing expected");
            end else begin
                want = verdict_q.pop_front();
                check_field("drive_next",  32'(want.drive_next),  32'(o_drive_next));
                check_field("line_ok",     32'(want.line_ok),     32'(o_line_ok));
                check_field("round_done",  32'(want.round_done),  32'(o_round_done));
                check_field("round_ok",    32'(want.round_ok),    32'(o_round_ok));
                check_field("ok_tally",    32'(want.ok_tally),    32'(o_ok_tally));
                check_field("ng_tally",    32'(want.ng_tally),    32'(o_ng_tally));
                check_field("run_done",    32'(want.run_done),    32'(o_run_done));
                check_field("pin_sources", 32'(want.pin_sources), 32'(o_pin_sources));
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned       roll;
        int unsigned       n_items;
        int unsigned       live_items;
        int unsigned       phase;
        logic              b;
        logic [RECV_W-1:0] r;
        bit                start_fresh;
        logic [MODE_W-1:0] mode_pick;
        live_items = 0;
        phase      = 0;

        // reset
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
            end else begin
                send_step(directed_rows[i].begin_req, directed_rows[i].recv,
                          directed_rows[i].kind == ROW_FIXED, directed_rows[i].want);
            end
        end

        // random phases, each with its own settings and idling pattern
        while (live_items < RANDOM_ITEMS) begin
            settle();
            case (phase % 4)
                0: begin in_gap_pct = 0;         out_stall_pct = 0;         end
                1: begin in_gap_pct = GAP_HEAVY; out_stall_pct = 0;         end
                2: begin in_gap_pct = 0;         out_stall_pct = GAP_HEAVY; end
                default: begin in_gap_pct = GAP_LIGHT; out_stall_pct = GAP_LIGHT; end
            endcase

            // mostly known modes, now and then an unused code
            if ($urandom_range(0, 9) != 0)
                mode_pick = 3'($urandom_range(MODE_STRAIGHT, MODE_DEBUG));
            else
                mode_pick = 3'($urandom_range(MODE_DEBUG + 1, MODE_UNUSED));
            write_reg(REG_MODE, CFG_DATA_W'(mode_pick));
            if ($urandom_range(0, 1) != 0)
                write_reg(REG_MAP, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
            if ($urandom_range(0, 3) != 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    write_reg(REG_ROUNDS, CFG_DATA_W'($urandom_range(0, 4)));
                else if (roll < 90)
                    write_reg(REG_ROUNDS, CFG_DATA_W'($urandom_range(5, 20)));
                else
                    write_reg(REG_ROUNDS, 24'd999);
            end

            // most phases start a fresh run, the rest carry on with new settings
            start_fresh = ($urandom_range(0, 3) != 0);
            n_items = $urandom_range(40, 110);
            for (int i = 0; i < n_items; i++) begin
                roll = $urandom_range(0, 99);
                b = (i == 0 && start_fresh) || (!m_running && roll < 60) ||
                    (m_running && roll < 2);
                roll = $urandom_range(0, 99);
                if (b || !m_running)
                    r = 8'($urandom_range(0, 255));
                else if (cfg_mode == MODE_DEBUG)
                    r = (roll < 50) ? 8'(1 << $urandom_range(0, 7)) :
                        (roll < 65) ? 8'h00 : 8'($urandom_range(0, 255));
                else if (roll < 88)
                    r = pattern_for_wire(m_wire);
                else if (roll < 95)
                    r = pattern_for_wire(m_wire) ^ 8'(1 << $urandom_range(0, 7));
                else
                    r = 8'($urandom_range(0, 255));
                if (b || m_running) live_items++;
                send_step(b, r, 1'b0, RES_QUIET);
            end
            phase++;
        end

        // drain and let the pipeline run dry
        settle();
        repeat (8) @(negedge i_clk);
        if (fault_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
